// ----- hw/rtl/uwpsm_pkg.sv -----
package uwpsm_pkg;

	// Fixed field and register widths
	localparam int DIV_W      = 16;
	localparam int TICK_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MODE_W     = 2;
	localparam int BYTE_W     = 8;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Bus access codes
	typedef enum logic [1:0] {
		CMD_IDLE  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_DIVISOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE = 2'd2;

	// Stop length codes
	localparam logic [MODE_W-1:0] STOP_ONE      = 2'd0;
	localparam logic [MODE_W-1:0] STOP_HALF     = 2'd1;
	localparam logic [MODE_W-1:0] STOP_TWO      = 2'd2;
	localparam logic [MODE_W-1:0] STOP_ONE_HALF = 2'd3;

	// Parity codes
	localparam logic [MODE_W-1:0] PAR_NONE = 2'd0;
	localparam logic [MODE_W-1:0] PAR_EVEN = 2'd1;
	localparam logic [MODE_W-1:0] PAR_ODD  = 2'd2;

	// Receive flag bit positions
	localparam int FLAG_FULL    = 0;
	localparam int FLAG_PARITY  = 1;
	localparam int FLAG_FRAMING = 2;

	// Word on the request channel: one clock tick
	typedef struct packed {
		cmd_t              cmd;
		logic [BYTE_W-1:0] tx_byte;
		logic              rx_line;
	} req_word_t;

	// Word on the response channel: state at the start of the tick
	typedef struct packed {
		logic              tx_line;
		logic [BYTE_W-1:0] rx_byte;
		logic              tx_empty;
		logic              rx_full;
		logic              parity_error;
		logic              framing_error;
	} rsp_word_t;

	// Classified tick, as queued between front and back
	typedef struct packed {
		logic              wr;
		logic              rd;
		logic              clr;
		logic [BYTE_W-1:0] tx_byte;
		logic              rx_line;
	} item_t;

	// Configuration write
	typedef struct packed {
		logic                  en;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

// ----- hw/rtl/uwpsm_stream_if.sv -----
interface uwpsm_stream_if #(
	parameter type T = logic
);

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ----- hw/rtl/uwpsm_front.sv -----
module uwpsm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	uwpsm_stream_if.sink         req,
	input  logic                 q_full,
	output logic                 push,
	output uwpsm_pkg::item_t     push_word
);

	logic             valid_s1;
	uwpsm_pkg::item_t word_s1;
	uwpsm_pkg::item_t word_cls;

	// Take a new word whenever the stage is empty or drains into the queue
	assign req.ready = !valid_s1 || !q_full;
	assign push      = valid_s1 && !q_full;
	assign push_word = word_s1;

	// Classify the access
	always_comb begin
		word_cls.wr      = (req.data.cmd == uwpsm_pkg::CMD_WRITE);
		word_cls.rd      = (req.data.cmd == uwpsm_pkg::CMD_READ);
		word_cls.clr     = (req.data.cmd == uwpsm_pkg::CMD_CLEAR);
		word_cls.tx_byte = req.data.tx_byte;
		word_cls.rx_line = req.data.rx_line;
	end

	// Hold the stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Capture the classified word
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			word_s1 <= word_cls;
		end
	end

endmodule

// ----- hw/rtl/uwpsm_queue.sv -----
module uwpsm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  uwpsm_pkg::item_t push_word,
	output logic             full,
	input  logic             pop,
	output uwpsm_pkg::item_t head,
	output logic             empty
);

	uwpsm_pkg::item_t                    slot_q [uwpsm_pkg::QUEUE_DEPTH];
	logic [uwpsm_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [uwpsm_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [uwpsm_pkg::QCNT_W-1:0]        count_q;

	assign full  = (count_q == uwpsm_pkg::QCNT_W'(uwpsm_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> !(count_q == '0) || $past(pop))
		else $error("queue lost words while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= uwpsm_pkg::QCNT_W'(uwpsm_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// ----- hw/rtl/uwpsm_back.sv -----
module uwpsm_back #(
	parameter int DATA_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  uwpsm_pkg::cfg_wr_t cfg,
	input  uwpsm_pkg::item_t   head,
	input  logic               q_empty,
	output logic               pop,
	uwpsm_stream_if.source     rsp
);

	localparam int CNT_W = $clog2(DATA_BITS + 4);
	localparam int TW    = uwpsm_pkg::TICK_W;

	// Configuration
	logic [uwpsm_pkg::DIV_W-1:0]  div_q;
	logic [uwpsm_pkg::MODE_W-1:0] stop_q;
	logic [uwpsm_pkg::MODE_W-1:0] par_q;

	// Transmitter state
	logic [uwpsm_pkg::BYTE_W-1:0] tx_holding_q;
	logic                         tx_full_q;
	logic [DATA_BITS+1:0]         tx_shift_q;
	logic [CNT_W-1:0]             tx_bits_q;
	logic [TW-1:0]                tx_ticks_q;

	// Receiver state
	logic [DATA_BITS:0]           rx_shift_q;
	logic [CNT_W-1:0]             rx_bits_q;
	logic [TW-1:0]                rx_ticks_q;
	logic [DATA_BITS-1:0]         rx_data_q;
	logic [2:0]                   rx_flags_q;
	logic [1:0]                   rx_sync_q;

	// Output register
	logic                         rsp_valid_q;
	uwpsm_pkg::rsp_word_t         rsp_word_q;

	// Next-state values
	logic [uwpsm_pkg::BYTE_W-1:0] tx_holding_d;
	logic                         tx_full_d;
	logic [DATA_BITS+1:0]         tx_shift_d;
	logic [CNT_W-1:0]             tx_bits_d;
	logic [TW-1:0]                tx_ticks_d;
	logic [DATA_BITS:0]           rx_shift_d;
	logic [CNT_W-1:0]             rx_bits_d;
	logic [TW-1:0]                rx_ticks_d;
	logic [DATA_BITS-1:0]         rx_data_d;
	logic [2:0]                   rx_flags_d;
	logic [1:0]                   rx_sync_d;
	uwpsm_pkg::rsp_word_t         rsp_word_d;

	// Timing and parity helpers
	logic [TW-1:0]                div_ticks;
	logic [TW-1:0]                half_ticks;
	logic [TW-1:0]                stop_raw;
	logic [TW-1:0]                stop_ticks;
	logic [TW-1:0]                tx_period;
	logic [TW-1:0]                tx_inc;
	logic [TW-1:0]                rx_target;
	logic [TW-1:0]                rx_inc;
	logic                         par_on;
	logic                         par_odd;
	logic [DATA_BITS-1:0]         tx_data;
	logic                         tx_par;
	logic [DATA_BITS-1:0]         rx_frame_data;
	logic                         rx_par;
	logic [CNT_W-1:0]             rx_last;
	logic [CNT_W-1:0]             rx_idx;
	logic                         level;

	assign pop       = !q_empty && (!rsp_valid_q || rsp.ready);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_word_q;

	// Bit period, start half period, stop length and parity mode
	always_comb begin
		div_ticks  = (div_q == '0) ? TW'(1) : TW'(div_q);
		half_ticks = div_ticks >> 1;
		case (stop_q)
			uwpsm_pkg::STOP_HALF:     stop_raw = half_ticks;
			uwpsm_pkg::STOP_TWO:      stop_raw = div_ticks << 1;
			uwpsm_pkg::STOP_ONE_HALF: stop_raw = div_ticks + half_ticks;
			default:                  stop_raw = div_ticks;
		endcase
		stop_ticks = (stop_raw == '0) ? TW'(1) : stop_raw;
		par_on     = (par_q == uwpsm_pkg::PAR_EVEN) || (par_q == uwpsm_pkg::PAR_ODD);
		par_odd    = (par_q == uwpsm_pkg::PAR_ODD);
	end

	// Show the state at the start of the tick
	always_comb begin
		rsp_word_d.tx_line       = (tx_bits_q > CNT_W'(1)) ? tx_shift_q[0] : 1'b1;
		rsp_word_d.rx_byte       = uwpsm_pkg::BYTE_W'(rx_data_q);
		rsp_word_d.tx_empty      = !tx_full_q;
		rsp_word_d.rx_full       = rx_flags_q[uwpsm_pkg::FLAG_FULL];
		rsp_word_d.parity_error  = rx_flags_q[uwpsm_pkg::FLAG_PARITY];
		rsp_word_d.framing_error = rx_flags_q[uwpsm_pkg::FLAG_FRAMING];
	end

	// Transmitter: apply a write, advance one tick, reload from the holding register
	always_comb begin
		tx_holding_d = tx_holding_q;
		tx_full_d    = tx_full_q;
		if (head.wr && !tx_full_q) begin
			tx_holding_d = head.tx_byte;
			tx_full_d    = 1'b1;
		end
		tx_shift_d = tx_shift_q;
		tx_bits_d  = tx_bits_q;
		tx_ticks_d = tx_ticks_q;
		tx_period  = (tx_bits_q == CNT_W'(1)) ? stop_ticks : div_ticks;
		tx_inc     = tx_ticks_q + 1'b1;
		if (tx_bits_q != '0) begin
			if (tx_inc >= tx_period) begin
				tx_ticks_d = '0;
				tx_shift_d = {1'b1, tx_shift_q[DATA_BITS+1:1]};
				tx_bits_d  = tx_bits_q - 1'b1;
			end else begin
				tx_ticks_d = tx_inc;
			end
		end
		tx_data = DATA_BITS'(tx_holding_d);
		tx_par  = (^tx_data) ^ par_odd;
		if (tx_bits_d == '0 && tx_full_d) begin
			tx_shift_d = {tx_par & par_on, tx_data, 1'b0};
			tx_bits_d  = CNT_W'(DATA_BITS + 2) + CNT_W'(par_on);
			tx_ticks_d = '0;
			tx_full_d  = 1'b0;
		end
	end

	// Receiver: apply a read or clear, then sample the synchronised pin
	always_comb begin
		level     = rx_sync_q[1];
		rx_sync_d = {rx_sync_q[0], head.rx_line};
		rx_flags_d = rx_flags_q;
		if (head.rd) begin
			rx_flags_d = '0;
		end else if (head.clr) begin
			rx_flags_d = rx_flags_q & 3'b001;
		end
		rx_shift_d    = rx_shift_q;
		rx_bits_d     = rx_bits_q;
		rx_ticks_d    = rx_ticks_q;
		rx_data_d     = rx_data_q;
		rx_last       = CNT_W'(DATA_BITS + 2) + CNT_W'(par_on);
		rx_idx        = rx_bits_q - CNT_W'(2);
		rx_frame_data = rx_shift_q[DATA_BITS-1:0];
		rx_par        = (^rx_frame_data) ^ par_odd;
		rx_inc        = rx_ticks_q + 1'b1;
		if (rx_bits_q == CNT_W'(1)) begin
			rx_target = (half_ticks == '0) ? TW'(1) : half_ticks;
		end else begin
			rx_target = div_ticks;
		end
		if (rx_bits_q == '0) begin
			if (!level) begin
				rx_bits_d  = CNT_W'(1);
				rx_ticks_d = '0;
			end
		end else if (rx_inc < rx_target) begin
			rx_ticks_d = rx_inc;
		end else begin
			rx_ticks_d = '0;
			if (rx_bits_q == CNT_W'(1)) begin
				if (level) begin
					rx_bits_d = '0;
				end else begin
					rx_shift_d = '0;
					rx_bits_d  = CNT_W'(2);
				end
			end else if (rx_bits_q < rx_last) begin
				for (int i = 0; i <= DATA_BITS; i++) begin
					if (rx_idx == CNT_W'(i)) begin
						rx_shift_d[i] = rx_shift_q[i] | level;
					end
				end
				rx_bits_d = rx_bits_q + 1'b1;
			end else begin
				rx_data_d = rx_frame_data;
				rx_flags_d[uwpsm_pkg::FLAG_FULL] = 1'b1;
				if (par_on && (rx_shift_q[DATA_BITS] != rx_par)) begin
					rx_flags_d[uwpsm_pkg::FLAG_PARITY] = 1'b1;
				end
				if (!level) begin
					rx_flags_d[uwpsm_pkg::FLAG_FRAMING] = 1'b1;
				end
				rx_bits_d = '0;
			end
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= uwpsm_pkg::DIV_W'(16);
			stop_q <= uwpsm_pkg::STOP_ONE;
			par_q  <= uwpsm_pkg::PAR_NONE;
		end else if (cfg.en) begin
			case (cfg.idx)
				uwpsm_pkg::CFG_BIT_DIVISOR: div_q  <= cfg.data;
				uwpsm_pkg::CFG_STOP_MODE:   stop_q <= cfg.data[uwpsm_pkg::MODE_W-1:0];
				uwpsm_pkg::CFG_PARITY_MODE: par_q  <= cfg.data[uwpsm_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the serial state by one tick per popped word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_holding_q <= '0;
			tx_full_q    <= 1'b0;
			tx_shift_q   <= '1;
			tx_bits_q    <= '0;
			tx_ticks_q   <= '0;
			rx_shift_q   <= '0;
			rx_bits_q    <= '0;
			rx_ticks_q   <= '0;
			rx_data_q    <= '0;
			rx_flags_q   <= '0;
			rx_sync_q    <= '1;
		end else if (pop) begin
			tx_holding_q <= tx_holding_d;
			tx_full_q    <= tx_full_d;
			tx_shift_q   <= tx_shift_d;
			tx_bits_q    <= tx_bits_d;
			tx_ticks_q   <= tx_ticks_d;
			rx_shift_q   <= rx_shift_d;
			rx_bits_q    <= rx_bits_d;
			rx_ticks_q   <= rx_ticks_d;
			rx_data_q    <= rx_data_d;
			rx_flags_q   <= rx_flags_d;
			rx_sync_q    <= rx_sync_d;
		end
	end

	// Hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pop) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_word_q <= rsp_word_d;
		end
	end

`ifndef SYNTHESIS
	a_tx_reload: assert property (@(posedge clk) disable iff (!arst_n)
		!(tx_full_q && tx_bits_q == '0))
		else $error("transmitter idle with a byte held");
	a_tx_bits: assert property (@(posedge clk) disable iff (!arst_n)
		tx_bits_q <= CNT_W'(DATA_BITS + 3))
		else $error("transmit bit count out of range");
	a_rx_bits: assert property (@(posedge clk) disable iff (!arst_n)
		rx_bits_q <= CNT_W'(DATA_BITS + 3))
		else $error("receive bit count out of range");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(tx_bits_q) && $stable(rx_bits_q) && $stable(rx_flags_q))
		else $error("serial state moved without a tick");
`endif

endmodule

// ----- hw/rtl/uart_with_parity_and_stop_modes_unit.sv -----
// UART transmitter and receiver driven one peripheral clock tick per request word. Each word
// carries a bus access (idle, write transmit byte, read received byte, clear errors) and the
// sampled receive pin; each produces one response word showing the transmit pin, the received
// byte and the status flags as they stood before that tick. Frames are a start bit, DATA_BITS
// data bits LSB first, optional even or odd parity and a stop time of one, half, two or one and
// a half bit periods; the receiver samples mid-bit behind a two-stage synchroniser. Words flow
// through an input register, a four-entry queue and the serial engine with its output register,
// so one word is taken every clock when nothing stalls. The throughput is set by the serial
// engine, which advances one tick per cycle if unstalled. Configuration must be written through
// cfg_wr_en/cfg_index/cfg_wdata only while no word is in flight; the block does not enforce it.
module uart_with_parity_and_stop_modes_unit #(
	parameter int DATA_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	uwpsm_stream_if.sink                         req,
	uwpsm_stream_if.source                       rsp,
	input  logic                                 cfg_wr_en,
	input  logic [uwpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [uwpsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;
	uwpsm_pkg::item_t   push_word;
	uwpsm_pkg::item_t   head;
	uwpsm_pkg::cfg_wr_t cfg;

	// Bundle the configuration write
	assign cfg.en   = cfg_wr_en;
	assign cfg.idx  = cfg_index;
	assign cfg.data = cfg_wdata;

	uwpsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.push_word (push_word)
	);

	uwpsm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	uwpsm_back #(
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

// ----- tb/uart_with_parity_and_stop_modes_unit_tb.sv -----
module uart_with_parity_and_stop_modes_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import uwpsm_pkg::*;

	// Parity code outside the named ones: the block treats it as no parity
	localparam logic [MODE_W-1:0] PAR_SPARE = 2'd3;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned MAX_REPORTS    = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	uwpsm_stream_if #(.T(req_word_t)) req_ch ();
	uwpsm_stream_if #(.T(rsp_word_t)) rsp_ch ();

	uart_with_parity_and_stop_modes_unit #(.DATA_BITS(8)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Tick words waiting to be sent, status words waiting to be seen
	req_word_t pending_ticks[$];
	rsp_word_t expected_status[$];

	int unsigned ticks_queued;
	int unsigned frames_queued;
	int unsigned settings_run;
	int unsigned words_checked;
	int unsigned faults;
	int unsigned quiet_cycles;
	int unsigned req_gap;
	int unsigned rsp_hold;
	bit steady;

	// Predictor copy of the configuration
	logic [DIV_W-1:0]  cfg_div;
	logic [MODE_W-1:0] cfg_stop;
	logic [MODE_W-1:0] cfg_par;

	// Predictor copy of the serial state
	logic [BYTE_W-1:0] tx_hold;
	logic              tx_hold_full;
	logic [9:0]        tx_shift;
	logic [3:0]        tx_bits_left;
	logic [TICK_W-1:0] tx_tick;
	logic [8:0]        rx_shift;
	logic [3:0]        rx_bit_no;
	logic [TICK_W-1:0] rx_tick;
	logic [BYTE_W-1:0] rx_word;
	logic [2:0]        rx_status;
	logic [1:0]        rx_meta;

	function automatic int unsigned bit_len();
		return (cfg_div == '0) ? 1 : int'(cfg_div);
	endfunction

	function automatic int unsigned stop_len();
		int unsigned d;
		int unsigned t;
		d = bit_len();
		case (cfg_stop)
		STOP_HALF: t = d / 2;
		STOP_TWO: t = 2 * d;
		STOP_ONE_HALF: t = (3 * d) / 2;
		default: t = d;
		endcase
		return (t == 0) ? 1 : t;
	endfunction

	function automatic bit parity_on();
		return (cfg_par == PAR_EVEN) || (cfg_par == PAR_ODD);
	endfunction

	function automatic logic frame_parity(input logic [BYTE_W-1:0] b);
		return (^b) ^ (cfg_par == PAR_ODD);
	endfunction

	// Advance the transmitter one tick, reloading from the holding register when idle
	task automatic step_tx();
		int unsigned period;
		if (tx_bits_left != 0) begin
			period = (tx_bits_left == 1) ? stop_len() : bit_len();
			tx_tick = tx_tick + 1'b1;
			if (tx_tick >= period) begin
				tx_tick = '0;
				tx_shift = {1'b1, tx_shift[9:1]};
				tx_bits_left = tx_bits_left - 1'b1;
			end
		end
		if (tx_bits_left == 0 && tx_hold_full) begin
			tx_shift = {parity_on() ? frame_parity(tx_hold) : 1'b0, tx_hold, 1'b0};
			tx_bits_left = parity_on() ? 4'd11 : 4'd10;
			tx_tick = '0;
			tx_hold_full = 1'b0;
		end
	endtask

	// Advance the receiver one tick on the synchronised pin level
	task automatic step_rx(input logic lvl);
		int unsigned last_bit;
		int unsigned target;
		last_bit = parity_on() ? 11 : 10;
		if (rx_bit_no == 0) begin
			if (!lvl) begin
				rx_bit_no = 4'd1;
				rx_tick = '0;
			end
		end else begin
			target = bit_len();
			if (rx_bit_no == 1) begin
				target = target / 2;
				if (target == 0)
					target = 1;
			end
			rx_tick = rx_tick + 1'b1;
			if (rx_tick >= target) begin
				rx_tick = '0;
				if (rx_bit_no == 1) begin
					if (lvl) begin
						rx_bit_no = 4'd0;
					end else begin
						rx_shift = '0;
						rx_bit_no = 4'd2;
					end
				end else if (rx_bit_no < last_bit) begin
					rx_shift = rx_shift | (9'(lvl) << (rx_bit_no - 2));
					rx_bit_no = rx_bit_no + 1'b1;
				end else begin
					rx_word = rx_shift[7:0];
					rx_status[FLAG_FULL] = 1'b1;
					if (parity_on() && (rx_shift[8] != frame_parity(rx_shift[7:0])))
						rx_status[FLAG_PARITY] = 1'b1;
					if (!lvl)
						rx_status[FLAG_FRAMING] = 1'b1;
					rx_bit_no = 4'd0;
				end
			end
		end
	endtask

	// Work out the status word for one tick, then apply the access and advance
	task automatic advance_uart(input req_word_t w, output rsp_word_t r);
		logic lvl;
		r.tx_line       = (tx_bits_left > 1) ? tx_shift[0] : 1'b1;
		r.rx_byte       = rx_word;
		r.tx_empty      = !tx_hold_full;
		r.rx_full       = rx_status[FLAG_FULL];
		r.parity_error  = rx_status[FLAG_PARITY];
		r.framing_error = rx_status[FLAG_FRAMING];
		case (w.cmd)
		CMD_WRITE: begin
			if (!tx_hold_full) begin
				tx_hold = w.tx_byte;
				tx_hold_full = 1'b1;
			end
		end
		CMD_READ: begin
			rx_status = '0;
		end
		CMD_CLEAR: begin
			rx_status[FLAG_PARITY] = 1'b0;
			rx_status[FLAG_FRAMING] = 1'b0;
		end
		default: begin
		end
		endcase
		lvl = rx_meta[1];
		rx_meta = {rx_meta[0], w.rx_line};
		step_tx();
		step_rx(lvl);
	endtask

	task automatic report_fault(input string what);
		faults++;
		if (faults <= MAX_REPORTS)
			$display("%s", what);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want)
			report_fault($sformatf("status word %0d, %s: expected 'h%0h, got 'h%0h",
				words_checked, name, want, got));
	endtask

	// Drive tick words from the pending queue, with random gaps
	always @(posedge clk) begin : drive_ticks
		rsp_word_t predicted;
		bit present;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				advance_uart(req_ch.data, predicted);
				expected_status.push_back(predicted);
				void'(pending_ticks.pop_front());
			end
			// hold a word that has not been taken yet
			present = req_ch.valid && !req_ch.ready;
			if (!present) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (pending_ticks.size() != 0) begin
					if (!steady && $urandom_range(0, 7) == 0)
						req_gap = $urandom_range(1, 6) - 1;
					else
						present = 1'b1;
				end
			end
			req_ch.valid <= present;
			if (present)
				req_ch.data <= pending_ticks[0];
		end else begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
		end
	end

	// Compare each status word with the oldest prediction, with random stalls
	always @(posedge clk) begin : check_status
		rsp_word_t want;
		rsp_word_t got;
		if (arst_n) begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (expected_status.size() == 0) begin
					report_fault($sformatf("status word %0d arrived with none expected",
						words_checked));
				end else begin
					want = expected_status.pop_front();
					check_field("tx_line", 8'(want.tx_line), 8'(got.tx_line));
					check_field("rx_byte", want.rx_byte, got.rx_byte);
					check_field("tx_empty", 8'(want.tx_empty), 8'(got.tx_empty));
					check_field("rx_full", 8'(want.rx_full), 8'(got.rx_full));
					check_field("parity_error", 8'(want.parity_error), 8'(got.parity_error));
					check_field("framing_error", 8'(want.framing_error),
						8'(got.framing_error));
				end
				words_checked++;
			end
			if (rsp_hold > 0) begin
				rsp_hold--;
				rsp_ch.ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 7) == 0) begin
				rsp_hold = $urandom_range(1, 6) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end else begin
			rsp_ch.ready <= 1'b0;
		end
	end

	// End the run if words are outstanding but nothing moves
	always @(posedge clk) begin : watchdog
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (pending_ticks.size() == 0 && expected_status.size() == 0)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d ticks pending, %0d expected",
				quiet_cycles, pending_ticks.size(), expected_status.size());
			$display("uart_with_parity_and_stop_modes_unit verification failed");
			$finish;
		end
	end

	function automatic cmd_t pick_access(input bit no_reads);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return CMD_WRITE;
		if (!no_reads && r < 24)
			return CMD_READ;
		if (!no_reads && r < 30)
			return CMD_CLEAR;
		return CMD_IDLE;
	endfunction

	task automatic queue_tick(input cmd_t c, input logic [BYTE_W-1:0] b, input logic line);
		req_word_t w;
		w.cmd = c;
		w.tx_byte = b;
		w.rx_line = line;
		pending_ticks.push_back(w);
		ticks_queued++;
	endtask

	task automatic queue_bit(input logic line, input bit no_reads);
		repeat (bit_len())
			queue_tick(pick_access(no_reads), 8'($urandom), line);
	endtask

	// One receive frame at the current settings, sometimes with bad parity or a low stop
	task automatic queue_frame();
		logic [BYTE_W-1:0] b;
		logic par;
		bit no_reads;
		b = 8'($urandom);
		no_reads = ($urandom_range(0, 2) == 0);
		queue_bit(1'b0, no_reads);
		for (int i = 0; i < BYTE_W; i++)
			queue_bit(b[i], no_reads);
		if (parity_on()) begin
			par = frame_parity(b);
			if ($urandom_range(0, 5) == 0)
				par = ~par;
			queue_bit(par, no_reads);
		end
		queue_bit($urandom_range(0, 7) != 0, no_reads);
		repeat ($urandom_range(1, 3))
			queue_tick(pick_access(no_reads), 8'($urandom), 1'b1);
		frames_queued++;
	endtask

	// Mostly well-formed frames when the bit time is short, with noise, start glitches and quiet line between
	task automatic queue_phase(input int unsigned n);
		int unsigned stop_at;
		bit short_bits;
		stop_at = ticks_queued + n;
		short_bits = (bit_len() <= 8);
		while (ticks_queued < stop_at) begin
			case ($urandom_range(0, 9))
			0: begin
				repeat ($urandom_range(1, 8))
					queue_tick(pick_access(1'b0), 8'($urandom), 1'($urandom));
			end
			1: begin
				queue_tick(pick_access(1'b0), 8'($urandom), 1'b0);
				repeat (short_bits ? bit_len() + 2 : 4)
					queue_tick(pick_access(1'b0), 8'($urandom), 1'b1);
			end
			2: begin
				repeat ($urandom_range(1, 6))
					queue_tick(pick_access(1'b0), 8'($urandom), 1'b1);
			end
			default: begin
				if (short_bits)
					queue_frame();
				else
					queue_tick(pick_access(1'b0), 8'($urandom), 1'($urandom));
			end
			endcase
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
		CFG_BIT_DIVISOR: cfg_div = val;
		CFG_STOP_MODE: cfg_stop = val[MODE_W-1:0];
		CFG_PARITY_MODE: cfg_par = val[MODE_W-1:0];
		default: begin
		end
		endcase
	endtask

	task automatic set_config(input logic [DIV_W-1:0] div, input logic [MODE_W-1:0] stop,
			input logic [MODE_W-1:0] par);
		write_reg(CFG_BIT_DIVISOR, div);
		write_reg(CFG_STOP_MODE, 16'(stop));
		write_reg(CFG_PARITY_MODE, 16'(par));
		settings_run++;
	endtask

	// Wait until every tick has been taken and every status word seen, then let it drain
	task automatic settle();
		while (pending_ticks.size() != 0 || req_ch.valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : run
		logic [DIV_W-1:0] div;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		steady = 1'b0;

		cfg_div = 16'd16;
		cfg_stop = STOP_ONE;
		cfg_par = PAR_NONE;
		tx_hold = '0;
		tx_hold_full = 1'b0;
		tx_shift = '1;
		tx_bits_left = '0;
		tx_tick = '0;
		rx_shift = '0;
		rx_bit_no = '0;
		rx_tick = '0;
		rx_word = '0;
		rx_status = '0;
		rx_meta = '1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: byte extremes, a write dropped while the holding register is full,
		// read and clear with nothing received, and a start that is gone by mid start bit
		queue_tick(CMD_IDLE, 8'h00, 1'b1);
		queue_tick(CMD_WRITE, 8'hFF, 1'b1);
		queue_tick(CMD_WRITE, 8'h00, 1'b1);
		queue_tick(CMD_WRITE, 8'h5A, 1'b1);
		queue_tick(CMD_READ, 8'hFF, 1'b1);
		queue_tick(CMD_CLEAR, 8'h00, 1'b1);
		queue_tick(CMD_IDLE, 8'h00, 1'b0);
		repeat (12) queue_tick(pick_access(1'b0), 8'($urandom), 1'b1);
		settle();

		// Fixed settings, extremes among them
		set_config(16'd2, STOP_ONE, PAR_NONE);
		queue_phase(30);
		settle();
		set_config(16'd1, STOP_HALF, PAR_EVEN);
		queue_phase(20);
		settle();
		set_config(16'd0, STOP_ONE_HALF, PAR_ODD);
		queue_phase(20);
		settle();
		set_config(16'd3, STOP_TWO, PAR_ODD);
		queue_phase(30);
		settle();
		set_config(16'hFFFF, STOP_TWO, PAR_EVEN);
		queue_phase(15);
		settle();
		set_config(16'd4, STOP_ONE_HALF, PAR_SPARE);
		queue_phase(30);
		settle();

		// Random settings, mostly short bit times
		repeat (4) begin
			div = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(5, 8))
				: 16'($urandom_range(1, 4));
			set_config(div, MODE_W'($urandom_range(0, 3)), MODE_W'($urandom_range(0, 3)));
			queue_phase(20);
			settle();
		end

		// Last stretch with no idling on either side
		steady = 1'b1;
		set_config(16'd2, STOP_HALF, PAR_EVEN);
		queue_phase(30);
		settle();

		if (expected_status.size() != 0)
			report_fault($sformatf("%0d status words never arrived", expected_status.size()));

		$display("Sent %0d ticks over %0d settings, %0d receive frames among them.",
			ticks_queued, settings_run, frames_queued);
		$display("Checked %0d status words, %0d faults found.", words_checked, faults);
		if (faults == 0) begin
			$display("uart_with_parity_and_stop_modes_unit verification clean");
		end else begin
			$display("uart_with_parity_and_stop_modes_unit verification failed");
		end
		$finish;
	end

endmodule
